@@ rtl/bfpa_pkg.sv @@
// Package for the best-fit page allocator: sizes, status codes, request kind, config indices, sequencer states.
// No dependencies.
`default_nettype none
package bfpa_pkg;
  localparam int unsigned NumPagesDef  = 1024;
  localparam int unsigned PageBytesDef = 4096;
  localparam int unsigned MaxBlocksDef = 64;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StInvalid  = 3'd1;
  localparam logic [2:0] StNoFit    = 3'd2;
  localparam logic [2:0] StFull     = 3'd3;
  localparam logic [2:0] StNotFound = 3'd4;

  localparam logic KindAlloc = 1'b0;

  localparam logic CfgEnable = 1'b0;
  localparam logic CfgBase   = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SLOT, S_SCAN, S_MARK, S_FIND, S_UNMARK, S_OUT
  } state_e;
endpackage
`default_nettype wire

@@ rtl/best_fit_page_allocator_top.sv @@
// Top level of the best-fit page allocator: page bitmap memory, record table and sequencer.
// Depends on bfpa_pkg.
// Sequence: an allocation first searches the records for a free slot, then scans the whole bitmap
// and then marks the chosen pages one by one; a free searches the records and then clears the
// block's pages one by one. Each then holds its result until it is taken; invalid requests, and
// allocations while disabled, go straight to the result. Only one transaction is in flight at a
// time; the bitmap scan sets the pace, and the block is ready again in the cycle after the result leaves.
// After reset a clearing pass zeroes the bitmap before any item is taken.
`default_nettype none
module best_fit_page_allocator_top #(
  parameter int unsigned NUM_PAGES  = bfpa_pkg::NumPagesDef,
  parameter int unsigned PAGE_BYTES = bfpa_pkg::PageBytesDef,
  parameter int unsigned MAX_BLOCKS = bfpa_pkg::MaxBlocksDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: size_bytes [31:0], address [63:32]
  input  wire logic [63:0] s_axis_tdata,
  // tuser: kind
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: status [2:0], block_address [34:3], block_pages [45:35], block_bytes [68:46], pad
  output logic [71:0]      m_axis_tdata
);
  import bfpa_pkg::*;

  localparam int unsigned PW = $clog2(NUM_PAGES);
  localparam int unsigned CW = $clog2(NUM_PAGES + 1);
  localparam int unsigned BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned NW = (CW > BW) ? CW + 1 : BW + 1;
  localparam int unsigned OW = $clog2(PAGE_BYTES);
  localparam logic [32:0] HeapBytes = 33'(64'(NUM_PAGES) * 64'(PAGE_BYTES));

  // Page bitmap memory: one write and one registered read per cycle.
  logic mem_q [NUM_PAGES];
  logic          mem_we, mem_wd, mem_rd_q;
  logic [PW-1:0] mem_wa, mem_ra;
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    mem_rd_q <= mem_q[mem_ra];
  end

  // Records: valid bits reset, payload unreset and read through registers.
  logic [MAX_BLOCKS-1:0] rvalid_q;
  logic [PW-1:0] rfirst_q [MAX_BLOCKS];
  logic [CW-1:0] rpages_q [MAX_BLOCKS];
  logic [22:0]   rbytes_q [MAX_BLOCKS];
  logic [PW-1:0] rfirst_rd_q;
  logic [CW-1:0] rpages_rd_q;
  logic [22:0]   rbytes_rd_q;

  state_e state_q, state_d;
  logic          en_q;
  logic [31:0]   base_q;
  logic [NW-1:0] cnt_q, cnt_d;        // scan position, walks to NUM_PAGES+1
  logic [CW-1:0] run_q, run_d, best_len_q, best_len_d, need_q;
  logic [PW-1:0] best_at_q, best_at_d;
  logic          found_q, found_d;
  logic [BW-1:0] slot_q, slot_d;
  logic          kind_q;
  logic [31:0]   size_q;
  logic [PW:0]   page_q;
  logic [2:0]    ost_q, ost_d;
  logic [31:0]   oaddr_q, oaddr_d;
  logic [CW-1:0] opages_q, opages_d;
  logic [22:0]   obytes_q, obytes_d;
  logic [PW-1:0] k_q, k_d;

  wire [31:0] base_al = {base_q[31:OW], {OW{1'b0}}};
  wire [32:0] offs    = {1'b0, s_axis_tdata[63:32]} - {1'b0, base_al};
  wire        accept  = s_axis_tvalid && s_axis_tready;
  wire [32:0] need_w  = ({1'b0, s_axis_tdata[31:0]} + 33'(PAGE_BYTES - 1)) >> OW;
  wire [BW-1:0] rec_ra   = cnt_q[BW-1:0];
  wire [BW-1:0] find_idx = BW'(cnt_q - 1'b1);

  // Next state and datapath.
  always_comb begin
    state_d = state_q; cnt_d = cnt_q; run_d = run_q; best_len_d = best_len_q;
    best_at_d = best_at_q; found_d = found_q; slot_d = slot_q; k_d = k_q;
    ost_d = ost_q; oaddr_d = oaddr_q; opages_d = opages_q; obytes_d = obytes_q;
    mem_ra = cnt_q[PW-1:0]; mem_we = 1'b0; mem_wa = cnt_q[PW-1:0]; mem_wd = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == NW'(NUM_PAGES - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          ost_d = StOk; oaddr_d = '0; opages_d = '0; obytes_d = '0;
          if (s_axis_tuser == KindAlloc) begin
            if (s_axis_tdata[31:0] == 32'd0 || {1'b0, s_axis_tdata[31:0]} > HeapBytes) begin
              ost_d = StInvalid; state_d = S_OUT;
            end else if (!en_q) begin
              ost_d = StNoFit; state_d = S_OUT;
            end else state_d = S_SLOT;
          end else begin
            if (s_axis_tdata[63:32] == 32'd0 || offs[32] || offs > HeapBytes) begin
              ost_d = StInvalid; state_d = S_OUT;
            end else state_d = S_FIND;
          end
        end
      end
      S_SLOT: begin
        if (!rvalid_q[cnt_q[BW-1:0]]) begin
          slot_d = cnt_q[BW-1:0]; cnt_d = '0; run_d = '0; found_d = 1'b0;
          best_len_d = CW'(NUM_PAGES); state_d = S_SCAN;
        end else if (cnt_q == NW'(MAX_BLOCKS - 1)) begin
          ost_d = StFull; state_d = S_OUT;
        end else cnt_d = cnt_q + 1'b1;
      end
      S_SCAN: begin
        // cnt_q is the read address; the bit for page cnt_q-1 is in mem_rd_q.
        cnt_d = cnt_q + 1'b1;
        if (cnt_q != '0) begin
          if (cnt_q <= NW'(NUM_PAGES) && !mem_rd_q) run_d = run_q + 1'b1;
          else begin
            if (run_q >= need_q && (!found_q || run_q < best_len_q)) begin
              best_len_d = run_q; found_d = 1'b1;
              best_at_d = PW'(cnt_q - 1'b1 - NW'(run_q));
            end
            run_d = '0;
          end
        end
        if (cnt_q == NW'(NUM_PAGES + 1)) begin
          k_d = '0;
          if (found_d) state_d = S_MARK;
          else begin ost_d = StNoFit; state_d = S_OUT; end
        end
      end
      S_MARK: begin
        mem_we = 1'b1; mem_wd = 1'b1; mem_wa = best_at_q + k_q;
        k_d = k_q + 1'b1;
        if ((CW)'(k_q) + 1'b1 == need_q) begin
          oaddr_d = base_al + (32'(best_at_q) << OW);
          opages_d = need_q; obytes_d = size_q[22:0]; state_d = S_OUT;
        end
      end
      S_FIND: begin
        // cnt_q is the record read address; the record of slot cnt_q-1 sits in the
        // registered read data, so the search runs one step behind the address.
        cnt_d = cnt_q + 1'b1;
        if (cnt_q != '0) begin
          if (rvalid_q[find_idx] && page_q >= (PW+1)'(rfirst_rd_q)
              && page_q < (PW+1)'(rfirst_rd_q) + (PW+1)'(rpages_rd_q)) begin
            slot_d = find_idx; k_d = '0; best_at_d = rfirst_rd_q;
            oaddr_d = base_al + (32'(rfirst_rd_q) << OW);
            opages_d = rpages_rd_q; obytes_d = rbytes_rd_q;
            state_d = S_UNMARK;
          end else if (cnt_q == NW'(MAX_BLOCKS)) begin
            ost_d = StNotFound; state_d = S_OUT;
          end
        end
      end
      S_UNMARK: begin
        // The freed block's first page is held in best_at_q and its length in opages_q.
        mem_we = 1'b1; mem_wa = best_at_q + k_q;
        k_d = k_q + 1'b1;
        if ((CW)'(k_q) + 1'b1 == opages_q) state_d = S_OUT;
      end
      S_OUT: if (m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    s_axis_tready = (state_q == S_IDLE);
    m_axis_tvalid = (state_q == S_OUT);
    m_axis_tdata  = {3'b000, obytes_q, 11'(opages_q), oaddr_q, ost_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; cnt_q <= '0; rvalid_q <= '0;
      en_q <= 1'b1; base_q <= 32'h8000_0000;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d;
      if (cfg_we_i && cfg_index_i == CfgEnable) en_q <= cfg_data_i[0];
      if (cfg_we_i && cfg_index_i == CfgBase) base_q <= cfg_data_i;
      if (state_q == S_MARK && state_d == S_OUT) rvalid_q[slot_q] <= 1'b1;
      if (state_q == S_UNMARK && state_d == S_OUT) rvalid_q[slot_q] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    run_q <= run_d; best_len_q <= best_len_d; best_at_q <= best_at_d;
    found_q <= found_d; slot_q <= slot_d; k_q <= k_d;
    ost_q <= ost_d; oaddr_q <= oaddr_d; opages_q <= opages_d; obytes_q <= obytes_d;
    if (accept) begin
      kind_q <= s_axis_tuser; size_q <= s_axis_tdata[31:0];
      need_q <= CW'(need_w); page_q <= (PW+1)'(offs >> OW);
    end
    if (state_q == S_MARK && state_d == S_OUT) begin
      rfirst_q[slot_q] <= best_at_q; rpages_q[slot_q] <= need_q;
      rbytes_q[slot_q] <= size_q[22:0];
    end
    rfirst_rd_q <= rfirst_q[rec_ra];
    rpages_rd_q <= rpages_q[rec_ra];
    rbytes_rd_q <= rbytes_q[rec_ra];
  end

  // Sequencer checks.
  a_out_ok_pages: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[2:0] == StOk) |-> m_axis_tdata[45:35] != 11'd0)
    else $error("ok result with zero pages");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[2:0] != StOk) |-> m_axis_tdata[34:3] == 32'd0)
    else $error("failure with nonzero address");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("ready right after accept");
  a_kind_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> kind_q == KindAlloc)
    else $error("scan on free");
endmodule
`default_nettype wire

@@ tb/tb_best_fit_page_allocator_top.sv @@
// Self-checking testbench for the best-fit page allocator top level.
// Depends on bfpa_pkg and best_fit_page_allocator_top; predicts every result in place.
`default_nettype none
module tb_best_fit_page_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bfpa_pkg::*;

  localparam int unsigned NPAGES  = NumPagesDef;
  localparam int unsigned PGBYTES = PageBytesDef;
  localparam int unsigned NBLOCKS = MaxBlocksDef;
  localparam logic        KindFree = ~KindAlloc;
  localparam longint unsigned HeapBytes = longint'(NPAGES) * PGBYTES;
  // Longest stretch without any accepted transaction before the run is declared hung.
  localparam int unsigned StallLimit = 30000;
  // Length of the one long receiver hold-off.
  localparam int unsigned HoldCycles = 6000;

  // One request as the sender sees it. When to_live is set the free address is picked at send
  // time inside a block that is live at that moment, or anywhere in the heap if none is live.
  typedef struct {
    logic        kind;
    logic [31:0] size;
    logic [31:0] addr;
    bit          to_live;
  } request_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] address;
    logic [10:0] pages;
    logic [22:0] bytes;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = CfgEnable;
  logic [31:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  wire  logic  s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        s_axis_tuser = KindAlloc;
  wire  logic  m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  logic [71:0] m_axis_tdata;

  best_fit_page_allocator_top DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Shadow copy of the allocator state and its two registers.
  bit          page_taken [NPAGES];
  bit          rec_live   [NBLOCKS];
  int unsigned rec_first  [NBLOCKS];
  int unsigned rec_npages [NBLOCKS];
  logic [31:0] rec_nbytes [NBLOCKS];
  bit          fit_on = 1'b1;
  logic [31:0] heap_base = 32'h8000_0000;

  request_t pending_reqs[$];
  answer_t  awaited_answers[$];
  request_t on_bus;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned errors = 0;
  int unsigned answers_seen = 0;

  function automatic longint unsigned page_base();
    return longint'(heap_base & ~(PGBYTES - 1));
  endfunction

  // Applies one request to the shadow state and returns what the block must answer.
  function automatic answer_t allocate_or_release(request_t rq);
    answer_t         ans;
    longint unsigned need, run, best_len, a, b, pg;
    int              best_at, slot;
    ans = '{status: StOk, address: '0, pages: '0, bytes: '0};
    if (rq.kind == KindAlloc) begin
      slot = -1;
      best_at = -1;
      run = 0;
      best_len = NPAGES + 1;
      if (rq.size == 0 || longint'(rq.size) > HeapBytes) begin
        ans.status = StInvalid;
        return ans;
      end
      if (!fit_on) begin
        ans.status = StNoFit;
        return ans;
      end
      for (int j = 0; j < NBLOCKS; j++) begin
        if (!rec_live[j] && slot < 0) slot = j;
      end
      if (slot < 0) begin
        ans.status = StFull;
        return ans;
      end
      need = (longint'(rq.size) + PGBYTES - 1) / PGBYTES;
      // A sentinel step past the last page closes a run that reaches the heap end.
      for (int j = 0; j <= NPAGES; j++) begin
        if (j < NPAGES && !page_taken[j]) begin
          run++;
        end else begin
          if (run >= need && run < best_len) begin
            best_len = run;
            best_at = j - int'(run);
          end
          run = 0;
        end
      end
      if (best_at < 0) begin
        ans.status = StNoFit;
        return ans;
      end
      for (int j = 0; j < need; j++) page_taken[best_at + j] = 1'b1;
      rec_live[slot] = 1'b1;
      rec_first[slot] = best_at;
      rec_npages[slot] = 32'(need);
      rec_nbytes[slot] = rq.size;
      ans.address = 32'(page_base() + longint'(best_at) * PGBYTES);
      ans.pages = 11'(need);
      ans.bytes = 23'(rq.size);
    end else begin
      a = rq.addr;
      b = page_base();
      if (a == 0 || a < b || a - b > HeapBytes) begin
        ans.status = StInvalid;
        return ans;
      end
      pg = (a - b) / PGBYTES;
      for (int i = 0; i < NBLOCKS; i++) begin
        if (rec_live[i] && pg >= rec_first[i] && pg < rec_first[i] + rec_npages[i]) begin
          for (int k = 0; k < rec_npages[i]; k++) page_taken[rec_first[i] + k] = 1'b0;
          ans.address = 32'(b + longint'(rec_first[i]) * PGBYTES);
          ans.pages = 11'(rec_npages[i]);
          ans.bytes = 23'(rec_nbytes[i]);
          rec_live[i] = 1'b0;
          return ans;
        end
      end
      ans.status = StNotFound;
    end
    return ans;
  endfunction

  // Picks an address somewhere inside a live block, or inside the heap if none is live.
  function automatic logic [31:0] live_block_address();
    int idx[$];
    int s;
    for (int i = 0; i < NBLOCKS; i++) if (rec_live[i]) idx.push_back(i);
    if (idx.size() == 0) return 32'(page_base() + $urandom_range(32'(HeapBytes - 1)));
    s = idx[$urandom_range(idx.size() - 1)];
    return 32'(page_base() + longint'(rec_first[s]) * PGBYTES +
               $urandom_range(rec_npages[s] * PGBYTES - 1));
  endfunction

  // Sender: a transaction completes on tvalid and tready; the next request is then
  // offered unless the sender chooses to idle this cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    request_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_answers.push_back(allocate_or_release(on_bus));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_reqs.pop_front();
          if (nxt.to_live) nxt.addr = live_block_address();
          on_bus = nxt;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {nxt.addr, nxt.size};
          s_axis_tuser <= nxt.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker. It also holds tready low for one long stretch early on,
  // so that the block backs up and stalls its input, and it runs the watchdog.
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no transaction for %0d cycles", $realtime, StallLimit);
        $display("FAILED: results differ");
        $finish;
      end else begin
        if (m_axis_tvalid && m_axis_tready) begin
          got.status  = m_axis_tdata[2:0];
          got.address = m_axis_tdata[34:3];
          got.pages   = m_axis_tdata[45:35];
          got.bytes   = m_axis_tdata[68:46];
          answers_seen++;
          if (awaited_answers.size() == 0) begin
            errors++;
            $display("%0t: unexpected result status %0d address %h", $realtime,
                     got.status, got.address);
          end else begin
            want = awaited_answers.pop_front();
            if (got.status !== want.status || got.address !== want.address ||
                got.pages !== want.pages || got.bytes !== want.bytes) begin
              errors++;
              $display("%0t: expected status %0d address %h pages %0d bytes %0d", $realtime,
                       want.status, want.address, want.pages, want.bytes);
              $display("%0t:   actual status %0d address %h pages %0d bytes %0d", $realtime,
                       got.status, got.address, got.pages, got.bytes);
            end
          end
        end
        if (!hold_done && answers_seen == 3) begin
          hold_done = 1'b1;
          hold_left = HoldCycles;
        end
        if (hold_left > 0) begin
          hold_left--;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
      end
    end
  end

  function automatic request_t alloc_req(logic [31:0] sz);
    return '{kind: KindAlloc, size: sz, addr: $urandom, to_live: 1'b0};
  endfunction

  function automatic request_t free_req(logic [31:0] ad);
    return '{kind: KindFree, size: $urandom, addr: ad, to_live: 1'b0};
  endfunction

  // Mostly small allocations and frees of live blocks, with some noise on top.
  function automatic request_t random_req(int unsigned alloc_pct);
    int unsigned r;
    request_t    rq;
    r = $urandom_range(99);
    if (r < alloc_pct) begin
      case ($urandom_range(9))
        0:       rq = alloc_req($urandom);
        1:       rq = alloc_req($urandom_range(1, 64) * PGBYTES);
        default: rq = alloc_req($urandom_range(1, 4 * PGBYTES));
      endcase
    end else if (r < 92) begin
      rq = free_req('0);
      rq.to_live = 1'b1;
    end else if (r < 96) begin
      rq = free_req($urandom);
    end else begin
      rq = free_req(32'(page_base() + $urandom_range(32'(HeapBytes))));
    end
    return rq;
  endfunction

  task automatic queue_random(int unsigned n, int unsigned alloc_pct);
    for (int i = 0; i < n; i++) pending_reqs.push_back(random_req(alloc_pct));
  endtask

  // The stimulus waits here until every request is sent, every expected result is back and the block is idle.
  task automatic drain();
    while (pending_reqs.size() > 0 || s_axis_tvalid || awaited_answers.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgEnable) fit_on = val[0];
    else heap_base = val;
  endtask

  initial begin
    logic [31:0] b;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Phase one: directed cases with the reset settings.
    send_idle_pct = 35;
    recv_idle_pct = 66;
    b = 32'h8000_0000;
    pending_reqs.push_back(alloc_req(32'd0));                  // zero size
    pending_reqs.push_back(alloc_req(32'hFFFF_FFFF));          // far too large
    pending_reqs.push_back(alloc_req(32'(HeapBytes + 1)));     // one byte over the heap
    pending_reqs.push_back(alloc_req(32'(HeapBytes)));         // whole heap
    pending_reqs.push_back(alloc_req(32'd1));                  // nothing left to fit
    pending_reqs.push_back(free_req(32'(b + HeapBytes)));      // exactly at the heap end
    pending_reqs.push_back(free_req(32'(b + HeapBytes + 1)));  // past the heap end
    pending_reqs.push_back(free_req(32'd0));                   // null address
    pending_reqs.push_back(free_req(b - 1));                   // below the base
    pending_reqs.push_back(free_req(b + 12345));               // inside the whole-heap block
    pending_reqs.push_back(free_req(b + 12345));               // now a miss
    pending_reqs.push_back(alloc_req(32'd1));
    pending_reqs.push_back(alloc_req(PGBYTES));
    pending_reqs.push_back(alloc_req(PGBYTES + 1));
    pending_reqs.push_back(alloc_req(3 * PGBYTES));
    pending_reqs.push_back(free_req(b + PGBYTES));
    pending_reqs.push_back(free_req(b + 6 * PGBYTES + PGBYTES - 1));
    // Holes of one, three and the tail: best fit must land in the three-page hole.
    pending_reqs.push_back(alloc_req(2 * PGBYTES));
    pending_reqs.push_back(alloc_req(32'd5));
    pending_reqs.push_back(alloc_req(32'd5));
    pending_reqs.push_back(free_req(32'hFFFF_FFFF));
    drain();
    queue_random(70, 55);
    drain();

    // Strategy off, then a moved base while blocks are still live.
    write_reg(CfgEnable, 32'd0);
    queue_random(10, 60);
    drain();
    write_reg(CfgEnable, 32'hFFFF_FFFF);
    write_reg(CfgBase, 32'h0000_0000);
    queue_random(50, 55);
    drain();

    // Phase two: the roles of sender and receiver idling swap.
    send_idle_pct = 66;
    recv_idle_pct = 35;
    write_reg(CfgBase, 32'hFFFF_FFFF);
    queue_random(20, 55);
    drain();
    write_reg(CfgBase, 32'h1234_5FFF);
    queue_random(50, 50);
    drain();

    // Phase three: no idling, heavy allocation so the record table fills up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CfgBase, 32'h7FFF_F000);
    queue_random(60, 80);
    drain();

    if (errors == 0 && awaited_answers.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
`default_nettype wire
